// ===== src/reduced_potential_energy_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Reduced potential energy unit: assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REDUCED_POTENTIAL_ENERGY_UNIT_ASSERT_SVH
`define REDUCED_POTENTIAL_ENERGY_UNIT_ASSERT_SVH

// same-cycle implication
`define RPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpe: same-cycle check failed");

// next-cycle implication
`define RPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpe: next-cycle check failed");

`endif

// ===== src/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg
// Codes, constants and types of the reduced potential energy unit.
// ----------------------------------------------------------------------------
package rpe_pkg;

  // register indexes
  localparam logic [1:0] CFG_IDX_TYPE  = 2'd0;
  localparam logic [1:0] CFG_IDX_UNIT  = 2'd1;
  localparam logic [1:0] CFG_IDX_COLS  = 2'd2;

  // potential forms
  localparam logic [2:0] PT_COLUMN  = 3'd0;
  localparam logic [2:0] PT_ENERGY  = 3'd1;
  localparam logic [2:0] PT_LAMBDA  = 3'd2;
  localparam logic [2:0] PT_PERTURB = 3'd3;
  localparam logic [2:0] PT_UMB1D   = 3'd4;
  localparam logic [2:0] PT_UMB2D   = 3'd5;

  // input units
  localparam logic [1:0] UNIT_REDUCED = 2'd0;
  localparam logic [1:0] UNIT_KCAL    = 2'd1;
  localparam logic [1:0] UNIT_KJ      = 2'd2;
  localparam logic [1:0] UNIT_RSVD    = 2'd3;

  // column counts that switch on the periodic wrap
  localparam logic [3:0] COLS_WRAP_1D = 4'd4;
  localparam logic [3:0] COLS_WRAP_X  = 4'd6;
  localparam logic [3:0] COLS_WRAP_Y  = 4'd7;

  // 1/kB and 1/(4.184 kB), unsigned Q.28
  localparam int          CONST_FRAC = 28;
  localparam int          FAC_W      = 38;
  localparam logic [FAC_W-1:0] INV_KCAL = 38'd135081975727;
  localparam logic [FAC_W-1:0] INV_KJ   = 38'd32285367047;

  // per-request sideband that rides along the pipeline
  typedef struct packed {
    logic        ovr;   // result fixed early
    logic        oerr;
    logic [31:0] oval;
    logic        neg;   // sign of the energy
    logic [31:0] tt;    // target temperature
  } side_t;

endpackage

// ===== src/reduced_potential_energy_unit.sv =====
// ----------------------------------------------------------------------------
// reduced_potential_energy_unit
// Reduced potential energy of one observation in a target state, Q16.16.
// ----------------------------------------------------------------------------
// One request per clock while in_stall_o is low.
// The pipeline is 47 register stages: 13 for the potential, the unit factor
// and the rounding offset, one for the overflow test, 32 for the restoring
// division by the target temperature (one quotient bit per stage), and the
// output register. Stalls collapse bubbles stage by stage, so requests keep
// flowing in while a result waits at the output as long as a stage is empty.
// Configuration is written through a plain write port and must only change
// while nothing is in flight.
module reduced_potential_energy_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] data_first_i,
  input  logic signed [31:0] data_second_i,
  input  logic [31:0] source_temperature_i,
  input  logic [31:0] target_temperature_i,
  input  logic signed [31:0] target_coef_a_i,
  input  logic signed [31:0] target_coef_b_i,
  input  logic signed [31:0] target_coef_c_i,
  input  logic signed [31:0] target_center_y_i,
  input  logic [30:0] target_period_x_i,
  input  logic [30:0] target_period_y_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] reduced_energy_o,
  output logic        range_error_o
);
  import rpe_pkg::*;

  localparam int QB      = 32;            // quotient bits
  localparam int ST_DIV0 = 13;            // overflow test stage
  localparam int ST_OUT  = ST_DIV0 + QB + 1;
  localparam int NS      = ST_OUT + 1;
  localparam int XW      = 98;            // signed potential
  localparam int MW      = XW - 1;
  localparam int PW      = 136;           // scaled magnitude
  localparam int ZW      = PW + 2;
  localparam int KW      = 6;
  // rounding shift per form and unit
  localparam int KR01 = 0;
  localparam int KR23 = FRAC_BITS;
  localparam int KR45 = 2 * FRAC_BITS + 1;
  localparam int KA01 = CONST_FRAC - FRAC_BITS;
  localparam int KA23 = CONST_FRAC;
  localparam int KA45 = FRAC_BITS + CONST_FRAC + 1;

  // ---------------------------------------------------------------- config
  logic [2:0] typ_q;
  logic [1:0] unit_q;
  logic [3:0] cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typ_q  <= PT_COLUMN;
      unit_q <= UNIT_REDUCED;
      cols_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_TYPE: typ_q  <= cfg_data_i[2:0];
        CFG_IDX_UNIT: unit_q <= cfg_data_i[1:0];
        CFG_IDX_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decoded controls; the user must keep them static while requests are in flight, the block does not enforce it
  logic [1:0]    unit_eff;
  logic          is_1d, is_2d, is_umb, is_lin, is_pert, bad_type, pass;
  logic          wrap_x_en, wrap_y_en;
  logic [KW-1:0] kshift;

  always_comb begin
    unit_eff  = (unit_q == UNIT_RSVD) ? UNIT_REDUCED : unit_q;
    is_1d     = (typ_q == PT_UMB1D);
    is_2d     = (typ_q == PT_UMB2D);
    is_umb    = is_1d | is_2d;
    is_pert   = (typ_q == PT_PERTURB);
    is_lin    = (typ_q == PT_LAMBDA) | is_pert;
    bad_type  = (typ_q > PT_UMB2D);
    pass      = (typ_q == PT_COLUMN) && (unit_eff == UNIT_REDUCED);
    wrap_x_en = is_1d ? (cols_q >= COLS_WRAP_1D) : (cols_q >= COLS_WRAP_X);
    wrap_y_en = (cols_q >= COLS_WRAP_Y);
    unique case (typ_q) inside
      PT_LAMBDA, PT_PERTURB:
        kshift = (unit_eff == UNIT_REDUCED) ? KW'(KR23) : KW'(KA23);
      PT_UMB1D, PT_UMB2D:
        kshift = (unit_eff == UNIT_REDUCED) ? KW'(KR45) : KW'(KA45);
      default:
        kshift = (unit_eff == UNIT_REDUCED) ? KW'(KR01) : KW'(KA01);
    endcase
  end

  // ------------------------------------------------------- stage handshake
  // A stage loads when the output moves or when it holds a bubble; a stage
  // that is passed on without reloading turns into a bubble.
  logic [NS-1:0] v_q, v_d, load;
  logic          go;

  always_comb begin
    go = !v_q[ST_OUT] || !out_stall_i;
    for (int i = 0; i < ST_OUT; i++) begin
      load[i] = go || !v_q[i];
    end
    load[ST_OUT] = go;
    v_d[0] = load[0] ? in_valid_i : (load[1] ? 1'b0 : v_q[0]);
    for (int i = 1; i < ST_OUT; i++) begin
      v_d[i] = load[i] ? v_q[i-1] : (load[i+1] ? 1'b0 : v_q[i]);
    end
    v_d[ST_OUT] = go ? v_q[ST_OUT-1] : v_q[ST_OUT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = v_q[ST_OUT];

  // ---------------------------------------------- S1: offsets and overrides
  logic signed [32:0] s1_dx_q, s1_dy_q;
  logic [31:0]        s1_px_q, s1_py_q;
  logic               s1_onx_q, s1_ony_q;
  logic [31:0]        s1_ka_q, s1_kb_q, s1_d0_q, s1_d1_q, s1_ts_q;
  side_t              s1_side_q;
  logic [31:0]        s1_cx, s1_px;
  side_t              s1_side;

  always_comb begin
    s1_cx = is_1d ? target_coef_b_i : target_coef_c_i;
    s1_px = is_1d ? target_coef_c_i : {1'b0, target_period_x_i};
    s1_side.ovr  = bad_type || pass || (target_temperature_i == '0);
    s1_side.oerr = !pass;
    s1_side.oval = (pass && !bad_type) ? data_first_i : '0;
    s1_side.neg  = 1'b0;
    s1_side.tt   = target_temperature_i;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_dx_q   <= {data_first_i[31], data_first_i} - {s1_cx[31], s1_cx};
      s1_dy_q   <= {data_second_i[31], data_second_i}
                 - {target_center_y_i[31], target_center_y_i};
      s1_px_q   <= s1_px;
      s1_py_q   <= {1'b0, target_period_y_i};
      s1_onx_q  <= wrap_x_en && !s1_px[31] && (s1_px != '0);
      s1_ony_q  <= wrap_y_en && (target_period_y_i != '0);
      s1_ka_q   <= target_coef_a_i;
      s1_kb_q   <= target_coef_b_i;
      s1_d0_q   <= data_first_i;
      s1_d1_q   <= data_second_i;
      s1_ts_q   <= source_temperature_i;
      s1_side_q <= s1_side;
    end
  end

  // ----------------------------------- S2: distances, lambda product
  logic [31:0]        s2_mx_q, s2_my_q, s2_px_q, s2_py_q;
  logic               s2_onx_q, s2_ony_q;
  logic [31:0]        s2_ka_q, s2_kb_q, s2_d0_q, s2_ts_q;
  logic signed [63:0] s2_pa_q;
  side_t              s2_side_q;
  logic [32:0]        s2_ax, s2_ay;
  logic signed [31:0] s2_mul_a, s2_mul_b;

  always_comb begin
    s2_ax    = s1_dx_q[32] ? (~s1_dx_q + 33'd1) : s1_dx_q;
    s2_ay    = s1_dy_q[32] ? (~s1_dy_q + 33'd1) : s1_dy_q;
    s2_mul_a = s1_ka_q;
    s2_mul_b = is_pert ? s1_d1_q : s1_d0_q;
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_mx_q   <= s2_ax[31:0];
      s2_my_q   <= s2_ay[31:0];
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
      s2_onx_q  <= s1_onx_q;
      s2_ony_q  <= s1_ony_q;
      s2_ka_q   <= s1_ka_q;
      s2_kb_q   <= s1_kb_q;
      s2_d0_q   <= s1_d0_q;
      s2_ts_q   <= s1_ts_q;
      s2_pa_q   <= s2_mul_a * s2_mul_b;
      s2_side_q <= s1_side_q;
    end
  end

  // ----------------------------- S3: minimum image, linear energy
  logic [31:0] s3_wx_q, s3_wy_q, s3_ka_q, s3_kb_q, s3_d0_q, s3_ts_q;
  logic [63:0] s3_lin_q;
  side_t       s3_side_q;
  logic [33:0] s3_tx, s3_ty, s3_tax, s3_tay;
  logic [63:0] s3_d0s;

  always_comb begin
    s3_tx  = {2'b00, s2_px_q} - {2'b00, s2_mx_q};
    s3_ty  = {2'b00, s2_py_q} - {2'b00, s2_my_q};
    s3_tax = s3_tx[33] ? (~s3_tx + 34'd1) : s3_tx;
    s3_tay = s3_ty[33] ? (~s3_ty + 34'd1) : s3_ty;
    s3_d0s = {{(32 - FRAC_BITS){s2_d0_q[31]}}, s2_d0_q, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_wx_q   <= (s2_onx_q && ({s2_mx_q, 1'b0} > {1'b0, s2_px_q}))
                 ? s3_tax[31:0] : s2_mx_q;
      s3_wy_q   <= (s2_ony_q && ({s2_my_q, 1'b0} > {1'b0, s2_py_q}))
                 ? s3_tay[31:0] : s2_my_q;
      s3_lin_q  <= is_pert ? (s3_d0s + s2_pa_q) : s2_pa_q;
      s3_ka_q   <= s2_ka_q;
      s3_kb_q   <= s2_kb_q;
      s3_d0_q   <= s2_d0_q;
      s3_ts_q   <= s2_ts_q;
      s3_side_q <= s2_side_q;
    end
  end

  // ------------------------------------------------------ S4: squares
  logic [63:0] s4_sx_q, s4_sy_q, s4_lin_q;
  logic [31:0] s4_ka_q, s4_kb_q, s4_d0_q, s4_ts_q;
  side_t       s4_side_q;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_sx_q   <= s3_wx_q * s3_wx_q;
      s4_sy_q   <= s3_wy_q * s3_wy_q;
      s4_lin_q  <= s3_lin_q;
      s4_ka_q   <= s3_ka_q;
      s4_kb_q   <= s3_kb_q;
      s4_d0_q   <= s3_d0_q;
      s4_ts_q   <= s3_ts_q;
      s4_side_q <= s3_side_q;
    end
  end

  // ---------------------------- S5: force constant partial products
  logic [63:0] s5_pxl_q, s5_pxh_q, s5_pyl_q, s5_pyh_q, s5_lin_q;
  logic        s5_kxn_q, s5_kyn_q;
  logic [31:0] s5_d0_q, s5_ts_q;
  side_t       s5_side_q;
  logic [31:0] s5_akx, s5_aky;

  always_comb begin
    s5_akx = s4_ka_q[31] ? (~s4_ka_q + 32'd1) : s4_ka_q;
    s5_aky = s4_kb_q[31] ? (~s4_kb_q + 32'd1) : s4_kb_q;
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s5_pxl_q  <= s4_sx_q[31:0] * s5_akx;
      s5_pxh_q  <= s4_sx_q[63:32] * s5_akx;
      s5_pyl_q  <= s4_sy_q[31:0] * s5_aky;
      s5_pyh_q  <= s4_sy_q[63:32] * s5_aky;
      s5_kxn_q  <= s4_ka_q[31];
      s5_kyn_q  <= s4_kb_q[31];
      s5_lin_q  <= s4_lin_q;
      s5_d0_q   <= s4_d0_q;
      s5_ts_q   <= s4_ts_q;
      s5_side_q <= s4_side_q;
    end
  end

  // ------------------------------------------------ S6: umbrella terms
  logic [95:0] s6_tx_q, s6_ty_q;
  logic        s6_kxn_q, s6_kyn_q;
  logic [63:0] s6_lin_q;
  logic [31:0] s6_d0_q, s6_ts_q;
  side_t       s6_side_q;

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s6_tx_q   <= {s5_pxh_q, 32'd0} + {32'd0, s5_pxl_q};
      s6_ty_q   <= {s5_pyh_q, 32'd0} + {32'd0, s5_pyl_q};
      s6_kxn_q  <= s5_kxn_q;
      s6_kyn_q  <= s5_kyn_q;
      s6_lin_q  <= s5_lin_q;
      s6_d0_q   <= s5_d0_q;
      s6_ts_q   <= s5_ts_q;
      s6_side_q <= s5_side_q;
    end
  end

  // ------------------------------------------- S7: signed potential
  logic [XW-1:0] s7_x_q;
  logic [31:0]   s7_ts_q;
  side_t         s7_side_q;
  logic [XW-1:0] s7_ex, s7_ey, s7_umb, s7_x;

  always_comb begin
    s7_ex  = {2'b00, s6_tx_q};
    s7_ey  = is_2d ? {2'b00, s6_ty_q} : '0;
    s7_ex  = s6_kxn_q ? (~s7_ex + XW'(1)) : s7_ex;
    s7_ey  = s6_kyn_q ? (~s7_ey + XW'(1)) : s7_ey;
    s7_umb = s7_ex + s7_ey;
    if (is_umb) begin
      s7_x = s7_umb;
    end else if (is_lin) begin
      s7_x = {{(XW - 64){s6_lin_q[63]}}, s6_lin_q};
    end else begin
      s7_x = {{(XW - 32){s6_d0_q[31]}}, s6_d0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      s7_x_q    <= s7_x;
      s7_ts_q   <= s6_ts_q;
      s7_side_q <= s6_side_q;
    end
  end

  // -------------------------------------- S8: magnitude, unit factor
  logic [MW-1:0]    s8_mag_q;
  logic [FAC_W-1:0] s8_fac_q;
  side_t            s8_side_q;
  logic [XW-1:0]    s8_abs;
  side_t            s8_side;

  always_comb begin
    s8_abs       = s7_x_q[XW-1] ? (~s7_x_q + XW'(1)) : s7_x_q;
    s8_side      = s7_side_q;
    s8_side.neg  = s7_x_q[XW-1];
  end

  always_ff @(posedge clk_i) begin
    if (load[7]) begin
      s8_mag_q <= s8_abs[MW-1:0];
      unique case (unit_eff)
        UNIT_KCAL: s8_fac_q <= INV_KCAL;
        UNIT_KJ:   s8_fac_q <= INV_KJ;
        default:   s8_fac_q <= {{(FAC_W - 32){1'b0}}, s7_ts_q};
      endcase
      s8_side_q <= s8_side;
    end
  end

  // ----------------------------------- S9: factor partial products
  localparam int PPW = 32 + FAC_W;
  logic [PPW-1:0] s9_pp_q [4];
  side_t          s9_side_q;
  logic [31:0]    s9_chunk [4];

  always_comb begin
    s9_chunk[0] = s8_mag_q[31:0];
    s9_chunk[1] = s8_mag_q[63:32];
    s9_chunk[2] = s8_mag_q[95:64];
    s9_chunk[3] = {{(128 - MW){1'b0}}, s8_mag_q[MW-1:96]};
  end

  always_ff @(posedge clk_i) begin
    if (load[8]) begin
      for (int j = 0; j < 4; j++) begin
        s9_pp_q[j] <= s9_chunk[j] * s8_fac_q;
      end
      s9_side_q <= s8_side_q;
    end
  end

  // ------------------------------------------- S10, S11: accumulate
  logic [PPW+32:0] s10_lo_q, s10_hi_q;
  side_t           s10_side_q;
  logic [PW-1:0]   s11_p_q;
  side_t           s11_side_q;

  always_ff @(posedge clk_i) begin
    if (load[9]) begin
      s10_lo_q   <= {1'b0, s9_pp_q[1], 32'd0} + {33'd0, s9_pp_q[0]};
      s10_hi_q   <= {1'b0, s9_pp_q[3], 32'd0} + {33'd0, s9_pp_q[2]};
      s10_side_q <= s9_side_q;
    end
    if (load[10]) begin
      s11_p_q    <= {{(PW - PPW - 33){1'b0}}, s10_lo_q}
                  + {s10_hi_q[PW-65:0], 64'd0};
      s11_side_q <= s10_side_q;
    end
  end

  // ---------------------------------- S12, S13: rounding and scaling
  // round(P / (Tt 2^k)) = floor(((2P + Tt 2^k) >> (k+1)) / Tt)
  logic [ZW-1:0] s12_z_q, s13_y_q;
  side_t         s12_side_q, s13_side_q;

  always_ff @(posedge clk_i) begin
    if (load[11]) begin
      s12_z_q    <= {1'b0, s11_p_q, 1'b0} + (ZW'(s11_side_q.tt) << kshift);
      s12_side_q <= s11_side_q;
    end
    if (load[12]) begin
      s13_y_q    <= s12_z_q >> ({1'b0, kshift} + 7'd1);
      s13_side_q <= s12_side_q;
    end
  end

  // --------------------------------------------- S14: overflow test
  logic [31:0] s14_r_q, s14_lo_q;
  logic        s14_big_q;
  side_t       s14_side_q;

  always_ff @(posedge clk_i) begin
    if (load[ST_DIV0]) begin
      s14_big_q  <= (s13_y_q[ZW-1:64] != '0) || (s13_y_q[63:32] >= s13_side_q.tt);
      s14_r_q    <= s13_y_q[63:32];
      s14_lo_q   <= s13_y_q[31:0];
      s14_side_q <= s13_side_q;
    end
  end

  // ------------------------------------ restoring divide, bit a stage
  logic [31:0] dv_r_q   [QB];
  logic [31:0] dv_q_q   [QB];
  logic [31:0] dv_lo_q  [QB];
  logic        dv_big_q [QB];
  side_t       dv_side_q[QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [31:0] r_in, q_in, lo_in;
    logic        big_in;
    side_t       side_in;
    logic [32:0] r2;
    logic        ge;

    if (j == 0) begin : g_first
      assign r_in    = s14_r_q;
      assign q_in    = '0;
      assign lo_in   = s14_lo_q;
      assign big_in  = s14_big_q;
      assign side_in = s14_side_q;
    end else begin : g_next
      assign r_in    = dv_r_q[j-1];
      assign q_in    = dv_q_q[j-1];
      assign lo_in   = dv_lo_q[j-1];
      assign big_in  = dv_big_q[j-1];
      assign side_in = dv_side_q[j-1];
    end

    assign r2 = {r_in, lo_in[QB-1-j]};
    assign ge = (r2 >= {1'b0, side_in.tt});

    always_ff @(posedge clk_i) begin
      if (load[ST_DIV0+1+j]) begin
        dv_r_q[j]    <= ge ? 32'(r2 - {1'b0, side_in.tt}) : r2[31:0];
        dv_q_q[j]    <= {q_in[30:0], ge};
        dv_lo_q[j]   <= lo_in;
        dv_big_q[j]  <= big_in;
        dv_side_q[j] <= side_in;
      end
    end
  end

  // ------------------------------------------- output: sign, saturate
  logic [31:0] fin_q;
  side_t       fin_side;
  logic [31:0] res_e;
  logic        res_f;

  always_comb begin
    fin_q    = dv_q_q[QB-1];
    fin_side = dv_side_q[QB-1];
    if (fin_side.ovr) begin
      res_e = fin_side.oval;
      res_f = fin_side.oerr;
    end else if (!fin_side.neg) begin
      if (dv_big_q[QB-1] || fin_q[31]) begin
        res_e = 32'h7FFF_FFFF;
        res_f = 1'b1;
      end else begin
        res_e = fin_q;
        res_f = 1'b0;
      end
    end else begin
      if (dv_big_q[QB-1] || (fin_q > 32'h8000_0000)) begin
        res_e = 32'h8000_0000;
        res_f = 1'b1;
      end else begin
        res_e = ~fin_q + 32'd1;
        res_f = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_OUT]) begin
      reduced_energy_o <= res_e;
      range_error_o    <= res_f;
    end
  end

endmodule

// ===== src/rpe_check.sv =====
// ----------------------------------------------------------------------------
// rpe_check
// Port-level checks of the reduced potential energy unit, bound to the top.
// ----------------------------------------------------------------------------
`include "reduced_potential_energy_unit_assert.svh"

module rpe_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [31:0] energy_i,
  input logic        error_i
);

  // a held result keeps its payload
  `RPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(energy_i) && $stable(error_i))

  // an empty output register never backs up the request side
  `RPE_ASSERT_SAME(a_flow_empty, clk_i, rst_ni, !out_valid_i, !in_stall_i)

  // requests back up only behind a blocked output
  `RPE_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)

  // a flagged result is zero or a saturation limit
  `RPE_ASSERT_SAME(a_err_value, clk_i, rst_ni, out_valid_i && error_i, energy_i == 32'h0000_0000 || energy_i == 32'h7FFF_FFFF || energy_i == 32'h8000_0000)

endmodule

bind reduced_potential_energy_unit rpe_check u_rpe_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .energy_i    (reduced_energy_o),
  .error_i     (range_error_o)
);
